[hw/rtl/rmv_pkg.sv]
// shared types and constants of the running mean / variance / min / max block
// no dependencies
`timescale 1ns / 1ps

package rmv_pkg;

  localparam int SampleW = 32;
  localparam int CountW  = 32;
  localparam int SumW    = 64;
  localparam int SvarW   = 64;
  localparam int VarW    = 63;
  localparam int StdW    = 40;

  // iterative divider: full 64 bit dividend or a 32 bit one
  localparam int DivLongSteps  = 64;
  localparam int DivShortSteps = 32;
  localparam int DivCntW       = $clog2(DivLongSteps + 1);

  // square root: one result bit per step
  localparam int SqrtSteps = StdW;
  localparam int SqrtCntW  = $clog2(SqrtSteps + 1);

  // func codes
  localparam logic FuncObserve = 1'b0;
  localparam logic FuncClear   = 1'b1;

  typedef struct packed {
    logic capture;
    logic update;
    logic var_zero;
    logic mdiv_start;
    logic mean_apply;
    logic mul;
    logic var_apply;
    logic vdiv_start;
    logic var_load;
    logic sqrt_start;
    logic std_load;
    logic load_out;
  } rmv_cmd_t;

  typedef struct packed {
    logic skip;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } rmv_sts_t;

endpackage

[hw/rtl/rmv_div.sv]
// restoring unsigned divider, one quotient bit per cycle
// depends on rmv_pkg
`timescale 1ns / 1ps

module rmv_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        short_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [rmv_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [31:0]                rem_q;
  logic [63:0]                dvd_q;
  logic [31:0]                dsr_q;
  logic [32:0]                rem_sh;
  logic [32:0]                diff;
  logic                       ge;

  assign rem_sh = {rem_q, dvd_q[63]};
  assign ge     = rem_sh >= {1'b0, dsr_q};
  assign diff   = rem_sh - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = short_i ? rmv_pkg::DivCntW'(rmv_pkg::DivShortSteps)
                       : rmv_pkg::DivCntW'(rmv_pkg::DivLongSteps);
    end else if (busy_q) begin
      cnt_d = cnt_q - rmv_pkg::DivCntW'(1);
      if (cnt_q == rmv_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= short_i ? {dividend_i[31:0], 32'h0} : dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : rem_sh[31:0];
      dvd_q <= {dvd_q[62:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

[hw/rtl/rmv_sqrt.sv]
// digit by digit integer square root of value * 2^16, one root bit per cycle
// depends on rmv_pkg
`timescale 1ns / 1ps

module rmv_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rmv_pkg::VarW-1:0] value_i,
  output logic                     done_o,
  output logic [rmv_pkg::StdW-1:0] root_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [rmv_pkg::SqrtCntW-1:0] cnt_q, cnt_d;
  logic [79:0]                  src_q;
  logic [43:0]                  rem_q;
  logic [39:0]                  root_q;
  logic [43:0]                  rem_sh;
  logic [43:0]                  trial;
  logic                         ge;

  assign rem_sh = {rem_q[41:0], src_q[79:78]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = rmv_pkg::SqrtCntW'(rmv_pkg::SqrtSteps);
    end else if (busy_q) begin
      cnt_d = cnt_q - rmv_pkg::SqrtCntW'(1);
      if (cnt_q == rmv_pkg::SqrtCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // 16 fraction bits appended below the value
      src_q  <= {1'b0, value_i, 16'h0};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      src_q <= {src_q[77:0], 2'b00};
      if (ge) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[38:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[38:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[hw/rtl/rmv_dp.sv]
// datapath: statistics registers, welford update, shared divider, square root,
// output register; depends on rmv_pkg, rmv_div, rmv_sqrt
`timescale 1ns / 1ps

module rmv_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              func_i,
  input  logic signed [rmv_pkg::SampleW-1:0] sample_i,
  input  rmv_pkg::rmv_cmd_t                 cmd_i,
  output rmv_pkg::rmv_sts_t                 sts_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [rmv_pkg::CountW-1:0]        count_o,
  output logic signed [rmv_pkg::SumW-1:0]   total_o,
  output logic signed [rmv_pkg::SampleW-1:0] mean_o,
  output logic [rmv_pkg::VarW-1:0]          variance_o,
  output logic [rmv_pkg::StdW-1:0]          std_dev_o,
  output logic signed [rmv_pkg::SampleW-1:0] maximum_o,
  output logic signed [rmv_pkg::SampleW-1:0] minimum_o
);

  // statistics
  logic [31:0]        cnt_q;
  logic signed [63:0] sum_q;
  logic signed [31:0] mean_q;
  logic [63:0]        svar_q;
  logic signed [31:0] max_q;
  logic signed [31:0] min_q;

  // captured word and work registers
  logic               func_q;
  logic signed [31:0] smp_q;
  logic [31:0]        d1_mag_q;
  logic               d1_neg_q;
  logic [31:0]        d2_mag_q;
  logic               prod_neg_q;
  logic [63:0]        prod_q;
  logic [62:0]        var_res_q;
  logic [39:0]        std_res_q;

  logic               out_valid_q;
  logic [31:0]        out_cnt_q;
  logic signed [63:0] out_sum_q;
  logic signed [31:0] out_mean_q;
  logic [62:0]        out_var_q;
  logic [39:0]        out_std_q;
  logic signed [31:0] out_max_q;
  logic signed [31:0] out_min_q;

  logic               skip;
  logic [31:0]        cnt_inc;
  logic [64:0]        sum_ext;
  logic [63:0]        sum_sat;
  logic [32:0]        d1;
  logic [32:0]        d1_abs;
  logic [33:0]        q_ext;
  logic [33:0]        q_sgn;
  logic [33:0]        m_wide;
  logic [31:0]        mean_new;
  logic [32:0]        d2;
  logic [32:0]        d2_abs;
  logic [63:0]        prod;
  logic [63:0]        var_inc;
  logic [64:0]        var_add;
  logic               div_start;
  logic [63:0]        div_dividend;
  logic [31:0]        div_divisor;
  logic               div_done;
  logic [63:0]        div_quo;
  logic               sqrt_done;
  logic [39:0]        sqrt_root;

  assign skip    = (func_q == rmv_pkg::FuncClear) || (cnt_q == '0);
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;

  // saturating sum
  assign sum_ext = {sum_q[63], sum_q} + {{33{smp_q[31]}}, smp_q};
  always_comb begin
    sum_sat = sum_ext[63:0];
    if (sum_ext[64] != sum_ext[63]) begin
      sum_sat = smp_q[31] ? {1'b1, 63'h0} : {1'b0, {63{1'b1}}};
    end
  end

  assign d1     = {smp_q[31], smp_q} - {mean_q[31], mean_q};
  assign d1_abs = d1[32] ? (~d1 + 33'd1) : d1;

  // new mean = old mean + signed quotient, clamped to 32 bits
  assign q_ext  = {2'b00, div_quo[31:0]};
  assign q_sgn  = d1_neg_q ? (~q_ext + 34'd1) : q_ext;
  assign m_wide = {{2{mean_q[31]}}, mean_q} + q_sgn;
  always_comb begin
    mean_new = m_wide[31:0];
    if (!((m_wide[33] == m_wide[32]) && (m_wide[32] == m_wide[31]))) begin
      mean_new = m_wide[33] ? {1'b1, 31'h0} : {1'b0, {31{1'b1}}};
    end
  end

  assign d2     = {smp_q[31], smp_q} - {mean_new[31], mean_new};
  assign d2_abs = d2[32] ? (~d2 + 33'd1) : d2;

  assign prod    = d1_mag_q * d2_mag_q;
  assign var_inc = {16'h0, prod_q[63:16]};
  assign var_add = {1'b0, svar_q} + {1'b0, var_inc};

  // shared divider: mean step or variance quotient
  assign div_start    = cmd_i.mdiv_start || cmd_i.vdiv_start;
  assign div_dividend = cmd_i.mdiv_start ? {32'h0, d1_mag_q} : svar_q;
  assign div_divisor  = cmd_i.mdiv_start ? cnt_q : cnt_q - 32'd1;

  rmv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .short_i    (cmd_i.mdiv_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  rmv_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i (var_res_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      mean_q <= '0;
      svar_q <= '0;
      max_q  <= '0;
      min_q  <= '0;
    end else begin
      if (cmd_i.update) begin
        if (func_q == rmv_pkg::FuncClear) begin
          cnt_q  <= '0;
          sum_q  <= '0;
          mean_q <= '0;
          svar_q <= '0;
          max_q  <= '0;
          min_q  <= '0;
        end else begin
          cnt_q <= cnt_inc;
          sum_q <= sum_sat;
          if (cnt_q == '0) begin
            // first sample seeds mean and extremes
            mean_q <= smp_q;
            svar_q <= '0;
            max_q  <= smp_q;
            min_q  <= smp_q;
          end else begin
            if (smp_q > max_q) max_q <= smp_q;
            if (smp_q < min_q) min_q <= smp_q;
          end
        end
      end
      if (cmd_i.mean_apply) begin
        mean_q <= mean_new;
      end
      if (cmd_i.var_apply) begin
        if (!prod_neg_q) begin
          svar_q <= var_add[64] ? '1 : var_add[63:0];
        end else begin
          svar_q <= (svar_q > var_inc) ? svar_q - var_inc : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      smp_q  <= sample_i;
    end
    if (cmd_i.update) begin
      d1_mag_q <= d1_abs[31:0];
      d1_neg_q <= d1[32];
    end
    if (cmd_i.mean_apply) begin
      d2_mag_q   <= d2_abs[31:0];
      prod_neg_q <= (d1_neg_q != d2[32]) && (d1_mag_q != '0) && (d2 != '0);
    end
    if (cmd_i.mul) begin
      prod_q <= prod;
    end
    if (cmd_i.var_zero) begin
      var_res_q <= '0;
      std_res_q <= '0;
    end
    if (cmd_i.var_load) begin
      var_res_q <= div_quo[63] ? {63{1'b1}} : div_quo[62:0];
    end
    if (cmd_i.std_load) begin
      std_res_q <= sqrt_root;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_cnt_q  <= cnt_q;
      out_sum_q  <= sum_q;
      out_mean_q <= mean_q;
      out_var_q  <= var_res_q;
      out_std_q  <= std_res_q;
      out_max_q  <= max_q;
      out_min_q  <= min_q;
    end
  end

  assign sts_o.skip      = skip;
  assign sts_o.div_done  = div_done;
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign count_o     = out_cnt_q;
  assign total_o     = out_sum_q;
  assign mean_o      = out_mean_q;
  assign variance_o  = out_var_q;
  assign std_dev_o   = out_std_q;
  assign maximum_o   = out_max_q;
  assign minimum_o   = out_min_q;

  // empty statistics are all zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (sum_q == '0 && mean_q == '0 && svar_q == '0 &&
                       max_q == '0 && min_q == '0))
    else $error("statistics not zero with zero count");

  // a single sample leaves no spread
  a_single_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 32'd1) |-> (svar_q == '0 && max_q == mean_q && min_q == mean_q))
    else $error("single sample state inconsistent");

  a_extremes_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_q >= min_q)
    else $error("maximum below minimum");

endmodule

[hw/rtl/rmv_ctrl.sv]
// controller: sequences capture, update, divisions, square root and output load
// depends on rmv_pkg
`timescale 1ns / 1ps

module rmv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output rmv_pkg::rmv_cmd_t cmd_o,
  input  rmv_pkg::rmv_sts_t sts_i
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StUpd   = 4'd1;
  localparam logic [3:0] StMdiv  = 4'd2;
  localparam logic [3:0] StMwait = 4'd3;
  localparam logic [3:0] StMean  = 4'd4;
  localparam logic [3:0] StMul   = 4'd5;
  localparam logic [3:0] StVar   = 4'd6;
  localparam logic [3:0] StVdiv  = 4'd7;
  localparam logic [3:0] StVwait = 4'd8;
  localparam logic [3:0] StSqrt  = 4'd9;
  localparam logic [3:0] StSwait = 4'd10;
  localparam logic [3:0] StOut   = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = StUpd;
      end
      StUpd: begin
        cmd_o.update = 1'b1;
        // clear or first sample: nothing to divide
        if (sts_i.skip) begin
          cmd_o.var_zero = 1'b1;
          state_d        = StOut;
        end else begin
          state_d = StMdiv;
        end
      end
      StMdiv: begin
        cmd_o.mdiv_start = 1'b1;
        state_d          = StMwait;
      end
      StMwait: begin
        if (sts_i.div_done) state_d = StMean;
      end
      StMean: begin
        cmd_o.mean_apply = 1'b1;
        state_d          = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StVar;
      end
      StVar: begin
        cmd_o.var_apply = 1'b1;
        state_d         = StVdiv;
      end
      StVdiv: begin
        cmd_o.vdiv_start = 1'b1;
        state_d          = StVwait;
      end
      StVwait: begin
        if (sts_i.div_done) begin
          cmd_o.var_load = 1'b1;
          state_d        = StSqrt;
        end
      end
      StSqrt: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = StSwait;
      end
      StSwait: begin
        if (sts_i.sqrt_done) begin
          cmd_o.std_load = 1'b1;
          state_d        = StOut;
        end
      end
      StOut: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == StMwait || state_q == StVwait))
    else $error("divider finished outside a wait state");

  a_sqrt_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.sqrt_done |-> (state_q == StSwait))
    else $error("square root finished outside its wait state");

  // never overwrite a word not yet taken
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("output register loaded while occupied");

endmodule

[hw/rtl/running_mean_variance_min_max.sv]
// running count, sum, mean, variance, std dev, max and min over Q16.16 samples
// a second or later sample passes a 32 step mean division, a 64 step variance division
// and a 40 step square root before out_valid_o; a clear or first sample goes straight
// to the output load. One word is in flight; the next is accepted the cycle after the
// output load, which is held while out_valid_o waits for out_ready_i
// reset (async, active low) zeroes all statistics and empties the output register
`timescale 1ns / 1ps

module running_mean_variance_min_max (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               func_i,
  input  logic signed [rmv_pkg::SampleW-1:0] sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rmv_pkg::CountW-1:0]         count_o,
  output logic signed [rmv_pkg::SumW-1:0]    total_o,
  output logic signed [rmv_pkg::SampleW-1:0] mean_o,
  output logic [rmv_pkg::VarW-1:0]           variance_o,
  output logic [rmv_pkg::StdW-1:0]           std_dev_o,
  output logic signed [rmv_pkg::SampleW-1:0] maximum_o,
  output logic signed [rmv_pkg::SampleW-1:0] minimum_o
);

  rmv_pkg::rmv_cmd_t cmd;
  rmv_pkg::rmv_sts_t sts;

  rmv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  rmv_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .func_i      (func_i),
    .sample_i    (sample_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .count_o     (count_o),
    .total_o     (total_o),
    .mean_o      (mean_o),
    .variance_o  (variance_o),
    .std_dev_o   (std_dev_o),
    .maximum_o   (maximum_o),
    .minimum_o   (minimum_o)
  );

endmodule
